/* design/jdc_pkg.sv */
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared types, constants and small tables for the Julian day / Gregorian
// date converter pipeline.
// ----------------------------------------------------------------------------
package jdc_pkg;

  // pipeline depth, accept to result
  localparam int JDC_LAT     = 12;
  // stages the date to day number path needs before it only delays
  localparam int JDC_FWD_STG = 4;

  // date check limits
  localparam int YEAR_LO = 1583;
  localparam int YEAR_HI = 4200;
  localparam int MONTH_HI = 12;

  // date to day number constants
  localparam int YEAR_BIAS  = 4800;
  localparam int CENT_BIAS  = 4900;
  localparam int JD_BASE    = 32075;
  localparam int QUAD_DAYS  = 1461;
  // floor(x / 100) == (x * DIV100_RCP) >> DIV100_SH for x below 2**14
  localparam int DIV100_RCP = 5243;
  localparam int DIV100_SH  = 19;

  // day number to date constants
  localparam int JD_SHIFT   = 68569;
  localparam int GREG_CYC   = 146097;
  localparam int CYC_RCP    = 229;       // floor(2**25 / 146097)
  localparam int YR_NUM     = 4000;
  localparam int YR_DEN     = 1461001;
  localparam int YR_RCP_NUM = 732000;    // 4000 * floor(2**28 / 1461001)
  localparam int MO_NUM     = 80;
  localparam int MO_DEN     = 2447;
  localparam int MO_RCP_NUM = 1040;      // 80 * floor(2**15 / 2447)
  localparam int DAY_BIAS   = 31;
  localparam int MO_WRAP    = 11;
  localparam int MO_YEAR    = 12;

  // date to day number result
  typedef struct packed {
    logic [21:0] jd;
    logic        ok;
  } fwd_res_t;

  // day number to date result
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        pos;
  } rev_res_t;

  // days in a month, zero for a month code that means nothing
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // (367 * (m - 2 - 12 * q)) / 12 with q = -1 for january and february
  function automatic logic [8:0] month_ofs(input logic [3:0] m);
    logic [8:0] ofs;
    case (m)
      4'd1:    ofs = 9'd336;
      4'd2:    ofs = 9'd367;
      4'd3:    ofs = 9'd30;
      4'd4:    ofs = 9'd61;
      4'd5:    ofs = 9'd91;
      4'd6:    ofs = 9'd122;
      4'd7:    ofs = 9'd152;
      4'd8:    ofs = 9'd183;
      4'd9:    ofs = 9'd214;
      4'd10:   ofs = 9'd244;
      4'd11:   ofs = 9'd275;
      4'd12:   ofs = 9'd305;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // (2447 * mm) / 80
  function automatic logic [8:0] day_ofs(input logic [3:0] mm);
    logic [8:0] ofs;
    case (mm)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd30;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd91;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd152;
      4'd6:    ofs = 9'd183;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd244;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd305;
      4'd11:   ofs = 9'd336;
      4'd12:   ofs = 9'd367;
      4'd13:   ofs = 9'd397;
      4'd14:   ofs = 9'd428;
      default: ofs = 9'd458;
    endcase
    return ofs;
  endfunction

endpackage

/* design/jdc_fwd.sv */
// ----------------------------------------------------------------------------
// jdc_fwd
// Date to day number path: date check and day number sum in four stages,
// then a delay line so the result lines up with the reverse path.
// ----------------------------------------------------------------------------
module jdc_fwd (
  input  logic                          clk,
  input  logic [jdc_pkg::JDC_LAT-1:0]   en,
  input  logic [4:0]                    day_in,
  input  logic [3:0]                    month_in,
  input  logic [12:0]                   year_in,
  output jdc_pkg::fwd_res_t             res
);

  localparam int NDLY = jdc_pkg::JDC_LAT - jdc_pkg::JDC_FWD_STG;

  // stage 1 registers
  logic [4:0]  day1_r;
  logic [3:0]  mon1_r;
  logic [12:0] year1_r;
  logic [13:0] yb1_r;
  logic [13:0] yc1_r;
  logic [8:0]  mo1_r;
  logic        rng1_r;
  // stage 2 registers
  logic [4:0]  day2_r;
  logic [3:0]  mon2_r;
  logic [12:0] year2_r;
  logic [8:0]  mo2_r;
  logic        rng2_r;
  logic [25:0] py2_r;
  logic [26:0] pc2_r;
  logic [24:0] pt2_r;
  // stage 3 registers
  logic [4:0]  day3_r;
  logic [3:0]  mon3_r;
  logic [8:0]  mo3_r;
  logic        rng3_r;
  logic        leap3_r;
  logic [22:0] t1_3_r;
  logic [7:0]  t3_3_r;
  // stage 4 and delay line
  jdc_pkg::fwd_res_t dly_r [0:NDLY];

  // stage 1 combinational
  logic        early;
  logic        rng;
  logic [13:0] yb1_nxt;
  logic [13:0] yc1_nxt;
  // stage 3 combinational
  logic [6:0]  q100;
  logic [12:0] rem_w;
  logic [6:0]  rem100;
  logic        leap;
  logic [7:0]  cdiv;
  logic [9:0]  t3w;
  // stage 4 combinational
  logic [4:0]  len;
  logic        ok;
  logic [23:0] sum;

  // year shifted to a march-based year, range check
  always_comb begin
    early   = (month_in < 4'd3);
    yb1_nxt = 14'(year_in) + 14'(jdc_pkg::YEAR_BIAS) - 14'(early);
    yc1_nxt = 14'(year_in) + 14'(jdc_pkg::CENT_BIAS) - 14'(early);
    rng     = (year_in >= 13'(jdc_pkg::YEAR_LO)) && (year_in <= 13'(jdc_pkg::YEAR_HI))
              && (month_in != 4'd0) && (month_in <= 4'(jdc_pkg::MONTH_HI));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      day1_r  <= day_in;
      mon1_r  <= month_in;
      year1_r <= year_in;
      yb1_r   <= yb1_nxt;
      yc1_r   <= yc1_nxt;
      mo1_r   <= jdc_pkg::month_ofs(month_in);
      rng1_r  <= rng;
    end
  end

  // constant multiplies: year / 100, century / 100, 1461 * year
  always_ff @(posedge clk) begin
    if (en[1]) begin
      day2_r  <= day1_r;
      mon2_r  <= mon1_r;
      year2_r <= year1_r;
      mo2_r   <= mo1_r;
      rng2_r  <= rng1_r;
      py2_r   <= 26'(year1_r) * 26'(jdc_pkg::DIV100_RCP);
      pc2_r   <= 27'(yc1_r) * 27'(jdc_pkg::DIV100_RCP);
      pt2_r   <= 25'(yb1_r) * 25'(jdc_pkg::QUAD_DAYS);
    end
  end

  // leap rule and century correction
  always_comb begin
    q100   = py2_r[25:19];
    rem_w  = year2_r - 13'(13'(q100) * 13'd100);
    rem100 = rem_w[6:0];
    leap   = ((year2_r[1:0] == 2'b00) && (rem100 != 7'd0))
             || ((rem100 == 7'd0) && (q100[1:0] == 2'b00));
    cdiv   = pc2_r[26:19];
    t3w    = 10'(cdiv) * 10'd3;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      day3_r  <= day2_r;
      mon3_r  <= mon2_r;
      mo3_r   <= mo2_r;
      rng3_r  <= rng2_r;
      leap3_r <= leap;
      t1_3_r  <= pt2_r[24:2];
      t3_3_r  <= t3w[9:2];
    end
  end

  // day check and final sum
  always_comb begin
    len = jdc_pkg::month_days(mon3_r, leap3_r);
    ok  = rng3_r && (day3_r != 5'd0) && (day3_r <= len);
    sum = 24'(day3_r) + 24'(t1_3_r) + 24'(mo3_r) - 24'(t3_3_r) - 24'(jdc_pkg::JD_BASE);
  end

  always_ff @(posedge clk) begin
    if (en[jdc_pkg::JDC_FWD_STG-1]) begin
      dly_r[0].jd <= ok ? sum[21:0] : 22'd0;
      dly_r[0].ok <= ok;
    end
  end

  // delay to the common output stage
  for (genvar k = 1; k <= NDLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[jdc_pkg::JDC_FWD_STG-1+k]) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign res = dly_r[NDLY];

endmodule

/* design/jdc_rev.sv */
// ----------------------------------------------------------------------------
// jdc_rev
// Day number to date path: three reciprocal-multiply divisions, each with
// a one-step correction, spread over twelve register stages.
// ----------------------------------------------------------------------------
module jdc_rev (
  input  logic                          clk,
  input  logic [jdc_pkg::JDC_LAT-1:0]   en,
  input  logic [21:0]                   jday_in,
  output jdc_pkg::rev_res_t             res
);

  // stage registers, numbered by stage
  logic [22:0] w0_1_r;
  logic        pos1_r;
  logic [24:0] x2_r;
  logic [31:0] pc2_r;
  logic        pos2_r;
  logic [6:0]  c3_r;
  logic [18:0] r3_r;
  logic        pos3_r;
  logic [6:0]  cent4_r;
  logic [15:0] wk4_r;
  logic        pos4_r;
  logic [27:0] x5_r;
  logic [34:0] py5_r;
  logic [6:0]  cent5_r;
  logic [15:0] wk5_r;
  logic        pos5_r;
  logic [6:0]  yy6_r;
  logic [21:0] r6_r;
  logic [6:0]  cent6_r;
  logic [15:0] wk6_r;
  logic        pos6_r;
  logic [6:0]  yy7_r;
  logic [6:0]  cent7_r;
  logic [15:0] wk7_r;
  logic        pos7_r;
  logic [8:0]  wk8_r;
  logic [6:0]  yy8_r;
  logic [6:0]  cent8_r;
  logic        pos8_r;
  logic [14:0] x9_r;
  logic [18:0] pm9_r;
  logic [8:0]  wk9_r;
  logic [6:0]  yy9_r;
  logic [6:0]  cent9_r;
  logic        pos9_r;
  logic [3:0]  mm10_r;
  logic [12:0] r10_r;
  logic [8:0]  wk10_r;
  logic [6:0]  yy10_r;
  logic [6:0]  cent10_r;
  logic        pos10_r;
  logic [3:0]  mm11_r;
  logic [8:0]  wk11_r;
  logic [6:0]  yy11_r;
  logic [6:0]  cent11_r;
  logic        pos11_r;
  jdc_pkg::rev_res_t res_r;

  // combinational per stage
  logic [24:0] x2;
  logic [6:0]  c0;
  logic [24:0] rw1;
  logic        ge1;
  logic [18:0] rr1;
  logic [16:0] inc;
  logic [6:0]  yy0;
  logic [27:0] rw2;
  logic [17:0] qd;
  logic [16:0] w2;
  logic [3:0]  mm0;
  logic [14:0] rw3;
  logic [9:0]  dw;
  logic        wrap;
  logic [4:0]  mw;
  logic [13:0] yw;

  // shift the day number onto the 400-year cycle
  always_ff @(posedge clk) begin
    if (en[0]) begin
      w0_1_r <= 23'(jday_in) + 23'(jdc_pkg::JD_SHIFT);
      pos1_r <= (jday_in != 22'd0);
    end
  end

  // 400-year cycle estimate
  assign x2 = {w0_1_r, 2'b00};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x2_r   <= x2;
      pc2_r  <= 32'(x2) * 32'(jdc_pkg::CYC_RCP);
      pos2_r <= pos1_r;
    end
  end

  // remainder of the cycle estimate
  always_comb begin
    c0  = pc2_r[31:25];
    rw1 = x2_r - 25'(25'(c0) * 25'(jdc_pkg::GREG_CYC));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c3_r   <= c0;
      r3_r   <= rw1[18:0];
      pos3_r <= pos2_r;
    end
  end

  // cycle correction, day within cycle is remainder / 4
  always_comb begin
    ge1 = (r3_r >= 19'(jdc_pkg::GREG_CYC));
    rr1 = ge1 ? (r3_r - 19'(jdc_pkg::GREG_CYC)) : r3_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cent4_r <= c3_r + 7'(ge1);
      wk4_r   <= rr1[17:2];
      pos4_r  <= pos3_r;
    end
  end

  // year in cycle estimate
  assign inc = 17'(wk4_r) + 17'd1;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      x5_r    <= 28'(inc) * 28'(jdc_pkg::YR_NUM);
      py5_r   <= 35'(inc) * 35'(jdc_pkg::YR_RCP_NUM);
      cent5_r <= cent4_r;
      wk5_r   <= wk4_r;
      pos5_r  <= pos4_r;
    end
  end

  // remainder of the year estimate
  always_comb begin
    yy0 = py5_r[34:28];
    rw2 = x5_r - 28'(28'(yy0) * 28'(jdc_pkg::YR_DEN));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      yy6_r   <= yy0;
      r6_r    <= rw2[21:0];
      cent6_r <= cent5_r;
      wk6_r   <= wk5_r;
      pos6_r  <= pos5_r;
    end
  end

  // year correction
  always_ff @(posedge clk) begin
    if (en[6]) begin
      yy7_r   <= yy6_r + 7'(r6_r >= 22'(jdc_pkg::YR_DEN));
      cent7_r <= cent6_r;
      wk7_r   <= wk6_r;
      pos7_r  <= pos6_r;
    end
  end

  // day within march-based year
  always_comb begin
    qd = 18'(yy7_r) * 18'(jdc_pkg::QUAD_DAYS);
    w2 = 17'(wk7_r) + 17'(jdc_pkg::DAY_BIAS) - 17'(qd[17:2]);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      wk8_r   <= w2[8:0];
      yy8_r   <= yy7_r;
      cent8_r <= cent7_r;
      pos8_r  <= pos7_r;
    end
  end

  // month estimate
  always_ff @(posedge clk) begin
    if (en[8]) begin
      x9_r    <= 15'(wk8_r) * 15'(jdc_pkg::MO_NUM);
      pm9_r   <= 19'(wk8_r) * 19'(jdc_pkg::MO_RCP_NUM);
      wk9_r   <= wk8_r;
      yy9_r   <= yy8_r;
      cent9_r <= cent8_r;
      pos9_r  <= pos8_r;
    end
  end

  // remainder of the month estimate
  always_comb begin
    mm0 = pm9_r[18:15];
    rw3 = x9_r - 15'(15'(mm0) * 15'(jdc_pkg::MO_DEN));
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      mm10_r   <= mm0;
      r10_r    <= rw3[12:0];
      wk10_r   <= wk9_r;
      yy10_r   <= yy9_r;
      cent10_r <= cent9_r;
      pos10_r  <= pos9_r;
    end
  end

  // month correction
  always_ff @(posedge clk) begin
    if (en[10]) begin
      mm11_r   <= mm10_r + 4'(r10_r >= 13'(jdc_pkg::MO_DEN));
      wk11_r   <= wk10_r;
      yy11_r   <= yy10_r;
      cent11_r <= cent10_r;
      pos11_r  <= pos10_r;
    end
  end

  // day, month, year; january and february roll into the next year
  always_comb begin
    dw   = 10'(wk11_r) - 10'(jdc_pkg::day_ofs(mm11_r));
    wrap = (mm11_r >= 4'(jdc_pkg::MO_WRAP));
    mw   = 5'(mm11_r) + 5'd2 - (wrap ? 5'(jdc_pkg::MO_YEAR) : 5'd0);
    yw   = 14'(14'(cent11_r) * 14'd100) - 14'(jdc_pkg::CENT_BIAS) + 14'(yy11_r)
           + 14'(wrap);
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      res_r.day   <= pos11_r ? dw[4:0] : 5'd0;
      res_r.month <= pos11_r ? mw[3:0] : 4'd0;
      res_r.year  <= pos11_r ? yw : 14'd0;
      res_r.pos   <= pos11_r;
    end
  end

  assign res = res_r;

endmodule

/* design/julian_day_date_converter.sv */
// throughput: one result beat per input beat, one beat per cycle unless stalled
// the twelve-stage day number to date path (three reciprocal-multiply divisions
// with a correction stage each) sets depth
// stalls fill bubbles first, so the input stays ready until all stages are full
// reset: synchronous active-low rst_n clears the stage valid bits only
// ----------------------------------------------------------------------------
// julian_day_date_converter
// Converts Gregorian dates to Julian day numbers and back, per beat,
// in a stallable twelve-stage pipeline.
// ----------------------------------------------------------------------------
module julian_day_date_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // day_in[4:0], month_in[8:5], year_in[21:9], jday_in[43:22], zero fill
  input  logic [47:0] in_tdata,
  // cmd[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // jday_out[21:0], day_out[26:22], month_out[30:27], year_out[44:31], zero fill
  output logic [47:0] out_tdata,
  // valid_res[0]
  output logic        out_tuser
);

  localparam int LAT = jdc_pkg::JDC_LAT;

  logic [LAT-1:0]    v_r;
  logic [LAT-1:0]    cmd_r;
  logic [LAT-1:0]    en;
  jdc_pkg::fwd_res_t fres;
  jdc_pkg::rev_res_t rres;
  logic              cmd_o;

  // stage load enables: a stage moves when it or any later stage is empty,
  // or when the result beat is taken
  for (genvar k = 0; k < LAT; k++) begin : g_en
    assign en[k] = out_tready || !(&v_r[LAT-1:k]);
  end

  assign in_tready = en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < LAT; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // direction select travels alongside
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd_r[0] <= in_tuser;
    end
    for (int k = 1; k < LAT; k++) begin
      if (en[k]) begin
        cmd_r[k] <= cmd_r[k-1];
      end
    end
  end

  jdc_fwd u_fwd (
    .clk      (clk),
    .en       (en),
    .day_in   (in_tdata[4:0]),
    .month_in (in_tdata[8:5]),
    .year_in  (in_tdata[21:9]),
    .res      (fres)
  );

  jdc_rev u_rev (
    .clk     (clk),
    .en      (en),
    .jday_in (in_tdata[43:22]),
    .res     (rres)
  );

  // result beat: only the chosen direction's fields are nonzero
  assign cmd_o      = cmd_r[LAT-1];
  assign out_tvalid = v_r[LAT-1];
  assign out_tuser  = cmd_o ? rres.pos : fres.ok;
  assign out_tdata  = {3'b000,
                       cmd_o ? rres.year  : 14'd0,
                       cmd_o ? rres.month : 4'd0,
                       cmd_o ? rres.day   : 5'd0,
                       cmd_o ? 22'd0      : fres.jd};

`ifndef SYNTHESIS
  // input only stalls once every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // an invalid result carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[44:0] == 45'd0))
    else $error("invalid result with nonzero fields");

  // a day number result carries no date
  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[21:0] != 22'd0) |-> (out_tdata[44:22] == 23'd0))
    else $error("day number and date both set");

  // a decoded date has a real month
  a_month_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && (out_tdata[21:0] == 22'd0)
    |-> (out_tdata[30:27] != 4'd0) && (out_tdata[30:27] <= 4'd12))
    else $error("decoded month out of range");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for julian_day_date_converter: random and directed date
// and day number beats go in, each result beat is checked field by field
// against a predictor of the Fliegel-Van Flandern conversion.
// ----------------------------------------------------------------------------

module tb;

  localparam logic CMD_TO_JDAY = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;
  localparam int   RAND_BEATS  = 1400;

  // expected result of one conversion beat
  typedef struct {
    logic [21:0] jd;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [13:0] yr;
    logic        ok;
  } conv_res_t;

  // predicts conversions and matches them against the result stream
  class date_jday_board;
    conv_res_t pending_replies[$];
    int        mismatches;
    int        date_beats;
    int        jday_beats;
    int        valid_seen;

    function new();
      mismatches = 0;
      date_beats = 0;
      jday_beats = 0;
      valid_seen = 0;
    endfunction

    static function bit leap_rule(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days in month m of year y, zero for a month code that means nothing
    static function int month_len(input longint m, input longint y);
      int len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = leap_rule(y) ? 29 : 28;
        default:               len = 0;
      endcase
      return len;
    endfunction

    // expected result for one input beat
    function conv_res_t convert(input logic cmd, input logic [47:0] data);
      conv_res_t r;
      longint d, m, y, j, q, w, cent, yy, mm, wrap;
      d = data[4:0];
      m = data[8:5];
      y = data[21:9];
      j = data[43:22];
      r.jd = '0; r.day = '0; r.mon = '0; r.yr = '0; r.ok = 1'b0;
      if (cmd == CMD_TO_JDAY) begin
        // range check, then the forward formula
        if (y >= 1583 && y <= 4200 && m >= 1 && m <= 12 && d >= 1 &&
            d <= month_len(m, y)) begin
          q = (m - 14) / 12;
          w = d - 32075 + (1461 * (y + 4800 + q)) / 4 + (367 * (m - 2 - q * 12)) / 12
              - (3 * ((y + 4900 + q) / 100)) / 4;
          r.jd = w[21:0];
          r.ok = 1'b1;
        end
      end else if (j > 0) begin
        // back to a calendar date
        w    = j + 68569;
        cent = (4 * w) / 146097;
        w    = w - (146097 * cent + 3) / 4;
        yy   = (4000 * (w + 1)) / 1461001;
        w    = w - (1461 * yy) / 4 + 31;
        mm   = (80 * w) / 2447;
        d    = w - (2447 * mm) / 80;
        wrap = mm / 11;
        m    = mm + 2 - 12 * wrap;
        y    = 100 * (cent - 49) + yy + wrap;
        r.day = d[4:0];
        r.mon = m[3:0];
        r.yr  = y[13:0];
        r.ok  = 1'b1;
      end
      return r;
    endfunction

    function void note_request(input logic cmd, input logic [47:0] data);
      if (cmd == CMD_TO_JDAY) date_beats++;
      else jday_beats++;
      pending_replies.push_back(convert(cmd, data));
    endfunction

    function void check_reply(input logic [47:0] data, input logic user);
      conv_res_t e;
      conv_res_t a;
      a.jd = data[21:0];
      a.day = data[26:22];
      a.mon = data[30:27];
      a.yr = data[44:31];
      a.ok = user;
      if (a.ok) valid_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: jd=%0d d=%0d m=%0d y=%0d ok=%0b",
                   a.jd, a.day, a.mon, $signed(a.yr), a.ok);
        return;
      end
      e = pending_replies.pop_front();
      if (a.jd !== e.jd || a.day !== e.day || a.mon !== e.mon || a.yr !== e.yr ||
          a.ok !== e.ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp jd=%0d d=%0d m=%0d y=%0d ok=%0b, got jd=%0d d=%0d m=%0d y=%0d ok=%0b",
                   e.jd, e.day, e.mon, $signed(e.yr), e.ok,
                   a.jd, a.day, a.mon, $signed(a.yr), a.ok);
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  date_jday_board board = new();
  bit             quiet;
  int             stall_left = 0;

  julian_day_date_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [47:0] pack_beat(input logic [4:0] d, input logic [3:0] m,
                                            input logic [12:0] y, input logic [21:0] j);
    return {4'b0, j, y, m, d};
  endfunction

  // one input beat, then a random gap
  task automatic send_beat(input logic cmd, input logic [47:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_date(input int d, input int m, input int y);
    send_beat(CMD_TO_JDAY, pack_beat(5'(d), 4'(m), 13'(y), 22'($urandom)));
  endtask

  task automatic send_jday(input int j);
    send_beat(CMD_TO_DATE, pack_beat(5'($urandom), 4'($urandom), 13'($urandom), 22'(j)));
  endtask

  // random well-formed date
  task automatic send_good_date();
    int y, m;
    y = $urandom_range(1583, 4200);
    m = $urandom_range(1, 12);
    send_date($urandom_range(1, board.month_len(m, y)), m, y);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) board.check_reply(out_tdata, out_tuser);
    end
  end

  // stimulus
  initial begin
    int r;
    int n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TO_JDAY;
    quiet      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // year limits and out of range fields
    send_date(1, 1, 1583);
    send_date(31, 12, 4200);
    send_date(31, 12, 1582);
    send_date(1, 1, 4201);
    send_date(0, 0, 0);
    send_date(31, 15, 8191);
    // leap rule
    send_date(29, 2, 2000);
    send_date(29, 2, 1900);
    send_date(29, 2, 2004);
    send_date(29, 2, 2001);
    send_date(28, 2, 2001);
    // day and month edges
    send_date(0, 3, 2020);
    send_date(31, 4, 2020);
    send_date(30, 4, 2020);
    send_date(1, 0, 2020);
    send_date(1, 13, 2020);
    // zero, earliest, largest and well-known day numbers
    send_jday(0);
    send_jday(1);
    send_jday(22'h3FFFFF);
    send_jday(2451545);
    send_jday(2299161);
    send_jday(2440588);
    send_jday(1721426);

    // random part, with stretches of no idling
    for (n = 0; n < RAND_BEATS; n++) begin
      quiet = ((n / 200) % 4) == 2;
      r = $urandom_range(99);
      if (r < 45) begin
        send_good_date();
      end else if (r < 55) begin
        // near the edges of the date check
        send_date($urandom_range(0, 31), $urandom_range(0, 13), $urandom_range(1580, 4203));
      end else if (r < 75) begin
        send_jday($urandom_range(2299000, 3255000));
      end else if (r < 85) begin
        send_jday($urandom_range(0, 2299000));
      end else begin
        send_beat(1'($urandom_range(0, 1)), {4'b0, 12'($urandom), 32'($urandom)});
        send_beat(1'($urandom_range(0, 1)), {4'b0, $urandom, 12'($urandom)});
      end
    end
    in_tvalid <= 1'b0;

    // drain, then watch for stray beats
    while (board.pending() != 0) @(posedge clk);
    repeat (4 * jdc_pkg::JDC_LAT) @(posedge clk);

    $display("covered %0d date beats and %0d day number beats, %0d valid results",
             board.date_beats, board.jday_beats, board.valid_seen);
    $display("mismatches: %0d, results still missing: %0d", board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

/* julian_day_date_converter.f */
design/jdc_pkg.sv
design/jdc_fwd.sv
design/jdc_rev.sv
design/julian_day_date_converter.sv
tb/tb.sv
